@@ rtl/core/rzpt_pkg.sv @@
// Shared types and constants of the rolling z-score pair trader.
// Holds the command/status structs, the register map and the saturation helper.
// No dependencies.
package rzpt_pkg;

  // Field widths that the interface fixes.
  localparam int ACT_W    = 2;
  localparam int POS_W    = 8;
  localparam int CASH_W   = 48;
  localparam int WIN_W    = 7;
  localparam int LIM_W    = 7;
  localparam int THR_W    = 16;
  localparam int SAT_W    = CASH_W + 2;
  // The threshold has 8 fraction bits, so its square has 16.
  localparam int LHS_SHIFT = 16;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_WINDOW    = 2'd0;
  localparam logic [ADDR_W-3:0] REG_POS_LIMIT = 2'd1;
  localparam logic [ADDR_W-3:0] REG_THRESHOLD = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RST    = 7'd20;
  localparam logic [LIM_W-1:0] POS_LIMIT_RST = 7'd5;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd512;

  localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
  localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } trade_e;

  typedef struct packed {
    logic [WIN_W-1:0] window_len;
    logic [LIM_W-1:0] position_limit;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  // One strobe per datapath step.
  typedef struct packed {
    logic capture;
    logic sq_new;
    logic sq_old;
    logic update;
    logic deviate;
    logic dev_sq;
    logic thr_sq;
    logic rhs_lo;
    logic rhs_hi;
    logic compare;
    logic trade;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } sts_t;

  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [SAT_W-1:0] v);
    logic signed [CASH_W-1:0] r;
    if (v > SAT_W'(CASH_MAX)) begin
      r = CASH_MAX;
    end else if (v < SAT_W'(CASH_MIN)) begin
      r = CASH_MIN;
    end else begin
      r = CASH_W'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rzpt_in_if.sv @@
// Input channel of the pair trader: valid/ready handshake with two prices.
// No dependencies.
interface rzpt_in_if #(
  parameter int PRICE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price_a;
  logic [PRICE_BITS-1:0] price_b;

  modport source (output valid, output price_a, output price_b, input ready);
  modport sink   (input valid, input price_a, input price_b, output ready);
endinterface

@@ rtl/core/rzpt_out_if.sv @@
// Output channel of the pair trader: valid/ready handshake with one trade result.
// No dependencies.
interface rzpt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         trade_action;
  logic signed [7:0]  position;
  logic signed [47:0] cash_flow;
  logic signed [47:0] settled_value;

  modport source (output valid, output trade_action, output position, output cash_flow,
                  output settled_value, input ready);
  modport sink   (input valid, input trade_action, input position, input cash_flow,
                  input settled_value, output ready);
endinterface

@@ rtl/core/rolling_zscore_pair_trader_unit.sv @@
// Top level of the rolling z-score pair trader.
// Depends on rzpt_pkg, rzpt_in_if, rzpt_out_if, rzpt_regs, rzpt_ctrl, rzpt_datapath.
//
//   channel  direction  handshake         payload
//   in_ch    sink       valid/ready       price_a, price_b
//   out_ch   source     valid/ready       trade_action, position, cash_flow, settled_value
//   apb      slave      psel/penable      window_len, position_limit, threshold
//
// While the window fills, a transaction ends after the window update with no result; once
// full, it runs on to the trade. One shared 32x32 multiplier serves seven separate steps.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// A result waits in the output register, and the next transaction is taken meanwhile;
// only the final step stalls when the previous result has not been taken.
module rolling_zscore_pair_trader_unit
  import rzpt_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rzpt_in_if.sink           in_ch,
  rzpt_out_if.source        out_ch
);

  cfg_t cfg;
  logic win_clr;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers; a window length write restarts the window fill.
  rzpt_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .win_clr_o (win_clr)
  );

  // The sequencer accepts a transaction only when it is idle and then walks
  // the datapath through its steps.
  rzpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the spread ring, the sums, the position and the cash,
  // and drives the output register directly.
  rzpt_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .win_clr_i       (win_clr),
    .price_a_i       (in_ch.price_a),
    .price_b_i       (in_ch.price_b),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .trade_action_o  (out_ch.trade_action),
    .position_o      (out_ch.position),
    .cash_flow_o     (out_ch.cash_flow),
    .settled_value_o (out_ch.settled_value),
    .sts_o           (sts)
  );

endmodule

@@ rtl/core/rzpt_regs.sv @@
// APB-style configuration registers of the pair trader.
// Depends on rzpt_pkg.
module rzpt_regs
  import rzpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              win_clr_o
);

  cfg_t                cfg_q;
  logic                wr_en;
  logic [ADDR_W-3:0]   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // A new window length restarts the fill of the window.
  assign win_clr_o = wr_en && (reg_idx == REG_WINDOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len     <= WINDOW_RST;
      cfg_q.position_limit <= POS_LIMIT_RST;
      cfg_q.threshold      <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW:    cfg_q.window_len     <= pwdata[WIN_W-1:0];
        REG_POS_LIMIT: cfg_q.position_limit <= pwdata[LIM_W-1:0];
        REG_THRESHOLD: cfg_q.threshold      <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW:    prdata = DATA_W'(cfg_q.window_len);
      REG_POS_LIMIT: prdata = DATA_W'(cfg_q.position_limit);
      REG_THRESHOLD: prdata = DATA_W'(cfg_q.threshold);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/rzpt_ctrl.sv @@
// Sequencer of the pair trader: steps one transaction through the datapath.
// Depends on rzpt_pkg.
module rzpt_ctrl
  import rzpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'h001,
    ST_SQN   = 12'h002,
    ST_SQO   = 12'h004,
    ST_UPD   = 12'h008,
    ST_DEV   = 12'h010,
    ST_D2    = 12'h020,
    ST_T2    = 12'h040,
    ST_RLO   = 12'h080,
    ST_RHI   = 12'h100,
    ST_CMP   = 12'h200,
    ST_TRADE = 12'h400,
    ST_EMIT  = 12'h800
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SQN;
        end
      end
      ST_SQN: begin
        cmd_o.sq_new = 1'b1;
        state_d      = ST_SQO;
      end
      ST_SQO: begin
        cmd_o.sq_old = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        // While the window fills, the transaction ends here with no result.
        cmd_o.update = 1'b1;
        state_d      = sts_i.full ? ST_DEV : ST_IDLE;
      end
      ST_DEV: begin
        cmd_o.deviate = 1'b1;
        state_d       = ST_D2;
      end
      ST_D2: begin
        cmd_o.dev_sq = 1'b1;
        state_d      = ST_T2;
      end
      ST_T2: begin
        cmd_o.thr_sq = 1'b1;
        state_d      = ST_RLO;
      end
      ST_RLO: begin
        cmd_o.rhs_lo = 1'b1;
        state_d      = ST_RHI;
      end
      ST_RHI: begin
        cmd_o.rhs_hi = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_TRADE;
      end
      ST_TRADE: begin
        cmd_o.trade = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/rzpt_datapath.sv @@
// Datapath of the pair trader: spread ring, running sums, shared multiplier,
// trade decision and output register. Depends on rzpt_pkg.
module rzpt_datapath
  import rzpt_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  cfg_t                     cfg_i,
  input  logic                     win_clr_i,
  input  logic [PRICE_BITS-1:0]    price_a_i,
  input  logic [PRICE_BITS-1:0]    price_b_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [ACT_W-1:0]         trade_action_o,
  output logic signed [POS_W-1:0]  position_o,
  output logic signed [CASH_W-1:0] cash_flow_o,
  output logic signed [CASH_W-1:0] settled_value_o,
  output sts_t                     sts_o
);

  localparam int PW    = PRICE_BITS;
  localparam int SW    = PW + 1;
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SW + AW;
  localparam int SQ_W  = 2 * PW + AW;
  localparam int D_W   = PW + AW + 2;
  localparam int MUL_W = (PW + AW + 1 > 32) ? PW + AW + 1 : 32;
  localparam int P_W   = 2 * MUL_W;
  localparam int V_W   = SQ_W + LW;
  localparam int R_W   = 3 * MUL_W;

  // Effective window length.
  logic [LW-1:0] n_w;
  always_comb begin
    if (cfg_i.window_len < WIN_W'(2)) begin
      n_w = LW'(2);
    end else if (int'(cfg_i.window_len) > MAX_WINDOW) begin
      n_w = LW'(MAX_WINDOW);
    end else begin
      n_w = LW'(cfg_i.window_len);
    end
  end

  // Window state.
  logic signed [SW-1:0]    ring_mem [MAX_WINDOW];
  logic signed [SW-1:0]    old_q;
  logic [AW-1:0]           slot_q;
  logic [LW-1:0]           fill_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sumsq_q;
  logic                    full_w;

  // Working registers of one transaction.
  logic signed [SW-1:0]    s_q;
  logic [SQ_W-1:0]         sqn_q;
  logic [SQ_W-1:0]         sqo_q;
  logic signed [D_W-1:0]   ns_q;
  logic signed [D_W-1:0]   d_q;
  logic [P_W-1:0]          sum2_q;
  logic [V_W-1:0]          nsq_q;
  logic [P_W-1:0]          d2_q;
  logic [V_W-1:0]          v_q;
  logic [MUL_W-1:0]        t2_q;
  logic [P_W-1:0]          plo_q;
  logic [P_W-1:0]          phi_q;
  logic                    trig_q;
  trade_e                  act_q;

  logic signed [POS_W-1:0]  held_q;
  logic signed [CASH_W-1:0] cash_q;

  assign full_w = (fill_q >= n_w);

  // Magnitudes feeding the multiplier.
  logic [SW-1:0]    s_abs, o_abs;
  logic [SUM_W-1:0] sum_abs;
  logic [D_W-1:0]   d_abs;
  assign s_abs   = s_q[SW-1]      ? SW'(-s_q)      : SW'(s_q);
  assign o_abs   = old_q[SW-1]    ? SW'(-old_q)    : SW'(old_q);
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign d_abs   = d_q[D_W-1]     ? D_W'(-d_q)     : D_W'(d_q);

  logic [P_W-1:0] v_ext;
  assign v_ext = P_W'(v_q);

  // Shared multiplier, one product per step.
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [P_W-1:0]   mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.sq_new) begin
      mul_a = MUL_W'(s_abs);
      mul_b = MUL_W'(s_abs);
    end else if (cmd_i.sq_old) begin
      mul_a = MUL_W'(o_abs);
      mul_b = MUL_W'(o_abs);
    end else if (cmd_i.deviate) begin
      mul_a = MUL_W'(sum_abs);
      mul_b = MUL_W'(sum_abs);
    end else if (cmd_i.dev_sq) begin
      mul_a = MUL_W'(d_abs);
      mul_b = MUL_W'(d_abs);
    end else if (cmd_i.thr_sq) begin
      mul_a = MUL_W'(cfg_i.threshold);
      mul_b = MUL_W'(cfg_i.threshold);
    end else if (cmd_i.rhs_lo) begin
      mul_a = t2_q;
      mul_b = v_ext[MUL_W-1:0];
    end else if (cmd_i.rhs_hi) begin
      mul_a = t2_q;
      mul_b = v_ext[P_W-1:MUL_W];
    end
  end
  assign mul_p = mul_a * mul_b;

  // Narrow side products.
  logic signed [D_W-1:0] n_sx, s_sx, ns_w;
  logic [V_W-1:0]        n_v, sq_v, nsq_w;
  assign n_sx  = D_W'($signed({1'b0, n_w}));
  assign s_sx  = D_W'(s_q);
  assign ns_w  = n_sx * s_sx;
  assign n_v   = V_W'(n_w);
  assign sq_v  = V_W'(sumsq_q);
  assign nsq_w = n_v * sq_v;

  // Window update.
  logic signed [SUM_W-1:0] sum_d;
  logic [SQ_W-1:0]         sumsq_d;
  logic [LW:0]             slot_inc;
  assign sum_d    = sum_q + SUM_W'(s_q) - (full_w ? SUM_W'(old_q) : SUM_W'(0));
  assign sumsq_d  = sumsq_q + sqn_q - (full_w ? sqo_q : SQ_W'(0));
  assign slot_inc = (LW + 1)'(slot_q) + (LW + 1)'(1);

  // Threshold test: D^2 * 2^16 against threshold^2 * V.
  logic [R_W-1:0] lhs_w, rhs_w;
  assign lhs_w = R_W'(d2_q) << LHS_SHIFT;
  assign rhs_w = (R_W'(phi_q) << MUL_W) + R_W'(plo_q);

  // Trade step.
  logic signed [POS_W-1:0] lim_w;
  logic signed [SAT_W-1:0] cash_buy, cash_sell, settle_w;
  assign lim_w     = POS_W'($signed({1'b0, cfg_i.position_limit}));
  assign cash_buy  = SAT_W'(cash_q) - SAT_W'(s_q);
  assign cash_sell = SAT_W'(cash_q) + SAT_W'(s_q);
  assign settle_w  = SAT_W'(cash_q) + SAT_W'(held_q) * SAT_W'(s_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[slot_q] <= s_q;
    end
    old_q <= ring_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= $signed({1'b0, price_a_i}) - $signed({1'b0, price_b_i});
    end
    if (cmd_i.sq_new) begin
      sqn_q <= SQ_W'(mul_p);
      ns_q  <= ns_w;
    end
    if (cmd_i.sq_old) begin
      sqo_q <= SQ_W'(mul_p);
    end
    if (cmd_i.deviate) begin
      d_q    <= ns_q - D_W'(sum_q);
      sum2_q <= mul_p;
      nsq_q  <= nsq_w;
    end
    if (cmd_i.dev_sq) begin
      d2_q <= mul_p;
      v_q  <= nsq_q - V_W'(sum2_q);
    end
    if (cmd_i.thr_sq) begin
      t2_q <= MUL_W'(mul_p);
    end
    if (cmd_i.rhs_lo) begin
      plo_q <= mul_p;
    end
    if (cmd_i.rhs_hi) begin
      phi_q <= mul_p;
    end
    if (cmd_i.compare) begin
      trig_q <= (lhs_w > rhs_w);
    end
    if (cmd_i.emit) begin
      trade_action_o  <= act_q;
      position_o      <= held_q;
      cash_flow_o     <= cash_q;
      settled_value_o <= sat_cash(settle_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (win_clr_i) begin
      slot_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cmd_i.update) begin
      sum_q   <= sum_d;
      sumsq_q <= sumsq_d;
      slot_q  <= (slot_inc >= (LW + 1)'(n_w)) ? '0 : AW'(slot_inc);
      if (!full_w) begin
        fill_q <= fill_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cash_q <= '0;
      act_q  <= ACT_NONE;
    end else if (cmd_i.trade) begin
      act_q <= ACT_NONE;
      if (trig_q && d_q[D_W-1]) begin
        if (held_q < lim_w) begin
          held_q <= held_q + POS_W'(1);
          cash_q <= sat_cash(cash_buy);
          act_q  <= ACT_BUY;
        end
      end else if (trig_q) begin
        // A trigger implies a nonzero deviation, so this is the high side.
        if (held_q > -lim_w) begin
          held_q <= held_q - POS_W'(1);
          cash_q <= sat_cash(cash_sell);
          act_q  <= ACT_SELL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign sts_o.full     = full_w;
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= n_w)
    else $error("fill count beyond window length");
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW + 1)'(slot_q) < (LW + 1)'(n_w))
    else $error("write slot outside window");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != {1'b1, {(POS_W-1){1'b0}}})
    else $error("position out of range");
  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |->
      (held_q == $past(held_q) + POS_W'(1) || held_q == $past(held_q) - POS_W'(1)))
    else $error("position moved by more than one unit");
`endif

endmodule

@@ tb/rolling_zscore_pair_trader_unit_test.sv @@
// Self-checking testbench of the rolling z-score pair trader unit.
// Predicts every trade result from its own model of the window statistics and trade rules.
// Depends on rzpt_pkg, rzpt_in_if, rzpt_out_if and the unit itself.
module rolling_zscore_pair_trader_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rzpt_pkg::*;

  localparam int MAXW = 64;
  localparam int PB = 24;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [7:0]  position;
    logic signed [47:0] cash;
    logic signed [47:0] settled;
  } trade_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rzpt_in_if #(.PRICE_BITS(PB)) in_ch ();
  rzpt_out_if out_ch ();

  rolling_zscore_pair_trader_unit #(.MAX_WINDOW(MAXW), .PRICE_BITS(PB)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the testbench's own copy of the configuration and the window.
  logic [6:0]         cfg_window;
  logic [6:0]         cfg_limit;
  logic [15:0]        cfg_thr;
  longint             win_spreads[MAXW];
  int                 next_slot;
  int                 filled;
  longint             run_sum;
  logic [63:0]        run_sq_sum;
  int                 held;
  longint             cash_acc;

  trade_result_t      expected_trades[$];
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 items_sent = 0;
  int                 trades_seen = 0;
  int                 cycles = 0;

  // Idling controls. When calm is set neither side idles; hold_off_cycles stalls the sink.
  bit                 calm = 1'b0;
  int                 hold_off_cycles = 0;

  function automatic longint clamp48(longint v);
    longint hi;
    hi = 64'sh7FFF_FFFF_FFFF;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void clear_stats();
    next_slot = 0;
    filled = 0;
    run_sum = 0;
    run_sq_sum = '0;
    foreach (win_spreads[k]) win_spreads[k] = 0;
  endfunction

  // Adds one price pair to the window and, if it was full already, works out the result.
  function automatic void predict_trade(logic [PB-1:0] pa, logic [PB-1:0] pb);
    int           n;
    longint       spread;
    longint       oldest;
    longint       dev;
    logic [63:0]  dev_sq;
    logic [63:0]  var_num;
    logic [63:0]  sum_mag;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [31:0]  thr_sq;
    bit           fire;
    trade_result_t r;
    n = (cfg_window < 2) ? 2 : (cfg_window > MAXW) ? MAXW : int'(cfg_window);
    spread = longint'(pa) - longint'(pb);
    if (filled < n) begin
      win_spreads[next_slot] = spread;
      run_sum += spread;
      run_sq_sum += 64'(spread * spread);
      filled++;
      next_slot = (next_slot + 1 >= n) ? 0 : next_slot + 1;
      return;
    end
    oldest = win_spreads[next_slot];
    win_spreads[next_slot] = spread;
    run_sum = run_sum - oldest + spread;
    run_sq_sum = run_sq_sum - 64'(oldest * oldest) + 64'(spread * spread);
    next_slot = (next_slot + 1 >= n) ? 0 : next_slot + 1;

    dev = longint'(n) * spread - run_sum;
    dev_sq = 64'(dev * dev);
    sum_mag = (run_sum < 0) ? 64'(-run_sum) : 64'(run_sum);
    var_num = 64'(n) * run_sq_sum - sum_mag * sum_mag;
    thr_sq = 32'(cfg_thr) * 32'(cfg_thr);
    lhs = {64'd0, dev_sq} << 16;
    rhs = 128'(thr_sq) * 128'(var_num);
    fire = lhs > rhs;

    r.action = ACT_NONE;
    if (fire && dev < 0) begin
      if (held < int'(cfg_limit)) begin
        held++;
        cash_acc = clamp48(cash_acc - spread);
        r.action = ACT_BUY;
      end
    end else if (fire && dev > 0) begin
      if (held > -int'(cfg_limit)) begin
        held--;
        cash_acc = clamp48(cash_acc + spread);
        r.action = ACT_SELL;
      end
    end
    r.position = 8'(held);
    r.cash = 48'(cash_acc);
    r.settled = 48'(clamp48(cash_acc + longint'(held) * spread));
    expected_trades = {expected_trades, r};
  endfunction

  // Sends one price pair as a transaction and predicts its result on acceptance.
  task automatic send_prices(logic [PB-1:0] pa, logic [PB-1:0] pb);
    while (!calm && $urandom_range(99) < 35) @(posedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.price_a <= pa;
    in_ch.price_b <= pb;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_trade(pa, pb);
    items_sent++;
    in_ch.valid <= 1'b0;
    // The block is busy after an acceptance anyway, so the offer drops before
    // the next transaction is driven.
    @(posedge clk_i);
  endtask

  // Waits until every predicted result has come, then lets the block settle.
  task automatic drain();
    while (expected_trades.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle. Only used with the block idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WINDOW: begin
        cfg_window = value[6:0];
        clear_stats();
      end
      REG_POS_LIMIT: cfg_limit = value[6:0];
      REG_THRESHOLD: cfg_thr = value[15:0];
      default: ;
    endcase
    // The bus goes idle between writes.
    @(posedge clk_i);
  endtask

  function automatic logic [PB-1:0] rand_price();
    return PB'($urandom);
  endfunction

  // A drifting pair: spread wanders around a level so that z-scores cross the threshold.
  task automatic send_walk(int count, int base, int spread_amp);
    int pa;
    for (int k = 0; k < count; k++) begin
      pa = base + $urandom_range(2000);
      send_prices(PB'(pa), PB'(pa - base / 8 + $urandom_range(2 * spread_amp) - spread_amp));
    end
  endtask

  // Directed: extreme prices, flat window, zero threshold and position limits.
  task automatic test_directed();
    write_reg(REG_WINDOW, 32'd2);
    write_reg(REG_POS_LIMIT, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    // Flat window: all spreads equal, so no trades.
    repeat (4) send_prices(24'd1000, 24'd1000);
    // Largest positive and negative spreads alternate and trade on zero threshold.
    send_prices(24'hFFFFFF, 24'd0);
    send_prices(24'd0, 24'hFFFFFF);
    send_prices(24'hFFFFFF, 24'd0);
    send_prices(24'd0, 24'hFFFFFF);
    send_prices(24'h555555, 24'hAAAAAA);
    send_prices(24'hAAAAAA, 24'h555555);
    drain();
    // Window of zero acts as two; limit zero bars the sells that rising spreads ask for.
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_POS_LIMIT, 32'd0);
    for (int k = 0; k < 6; k++) send_prices(PB'(k * 3000), 24'd100);
    drain();
    // Limit of one: it only bars further trades; a position kept before is not cut back.
    write_reg(REG_POS_LIMIT, 32'd1);
    write_reg(REG_THRESHOLD, 32'hFFFF);
    for (int k = 0; k < 5; k++) send_prices(PB'($urandom_range(5000)), 24'd2500);
    drain();
  endtask

  // Random walks across several settings, including the largest window.
  task automatic test_random_settings();
    int windows[4] = '{64, 127, 3, 20};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_WINDOW, 32'(windows[ph]));
      write_reg(REG_POS_LIMIT, (ph == 1) ? 32'd127 : 32'($urandom_range(8)));
      write_reg(REG_THRESHOLD, (ph == 2) ? 32'd0 : 32'($urandom_range(128, 700)));
      send_walk(90, $urandom_range(1000, 8000000), $urandom_range(10, 3000));
      for (int k = 0; k < 10; k++) send_prices(rand_price(), rand_price());
      drain();
    end
  endtask

  // The sink holds off for a long stretch while items keep coming, then the source
  // pauses until all results are in.
  task automatic test_backpressure();
    write_reg(REG_WINDOW, 32'd4);
    write_reg(REG_POS_LIMIT, 32'd127);
    write_reg(REG_THRESHOLD, 32'd200);
    hold_off_cycles = 300;
    calm = 1'b1;
    send_walk(40, 50000, 400);
    calm = 1'b0;
    drain();
    send_walk(40, 50000, 400);
    drain();
  endtask

  // No idling on either side, high threshold flips and random noise.
  task automatic test_calm_stream();
    write_reg(REG_WINDOW, 32'd8);
    write_reg(REG_THRESHOLD, 32'd300);
    calm = 1'b1;
    send_walk(60, 3000000, 20000);
    for (int k = 0; k < 20; k++) send_prices(rand_price(), rand_price());
    calm = 1'b0;
    drain();
  endtask

  // The sink's ready: random idling, a counted hold-off, or always high when calm.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    trade_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_trades.size() == 0) begin
        $display("%0t: result with none expected: action %0d position %0d", $time,
                 out_ch.trade_action, out_ch.position);
        mismatches++;
      end else begin
        want = expected_trades.pop_front();
        if (out_ch.trade_action != ACT_NONE) trades_seen++;
        if (out_ch.trade_action !== want.action) begin
          $display("%0t: trade_action expected %0d actual %0d", $time, want.action,
                   out_ch.trade_action);
          mismatches++;
        end
        if (out_ch.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_ch.position);
          mismatches++;
        end
        if (out_ch.cash_flow !== want.cash) begin
          $display("%0t: cash_flow expected %0d actual %0d", $time, want.cash,
                   out_ch.cash_flow);
          mismatches++;
        end
        if (out_ch.settled_value !== want.settled) begin
          $display("%0t: settled_value expected %0d actual %0d", $time, want.settled,
                   out_ch.settled_value);
          mismatches++;
        end
      end
    end
  end

  // The run is cut off at a generous cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.price_a = '0;
    in_ch.price_b = '0;
    out_ch.ready = 1'b0;
    cfg_window = WINDOW_RST;
    cfg_limit = POS_LIMIT_RST;
    cfg_thr = THRESHOLD_RST;
    held = 0;
    cash_acc = 0;
    clear_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    test_calm_stream();
    drain();
    if (expected_trades.size() != 0) mismatches++;
    $display("Sent %0d price pairs, checked %0d results, %0d of them trades.",
             items_sent, results_seen, trades_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
